// ===== hdl/peb_pkg.sv =====
// ----------------------------------------------------------------------------
// peb_pkg
// Shared types and constants for the polynomial extremum bisection block.
// ----------------------------------------------------------------------------
package peb_pkg;

    localparam int unsigned DATA_W  = 48;
    localparam int unsigned TOL_W   = 47;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned NUM_COEF = 6;

    localparam logic [IDX_W-1:0] REG_COEF0 = 3'd0;
    localparam logic [IDX_W-1:0] REG_COEF1 = 3'd1;
    localparam logic [IDX_W-1:0] REG_COEF2 = 3'd2;
    localparam logic [IDX_W-1:0] REG_COEF3 = 3'd3;
    localparam logic [IDX_W-1:0] REG_COEF4 = 3'd4;
    localparam logic [IDX_W-1:0] REG_COEF5 = 3'd5;
    localparam logic [IDX_W-1:0] REG_TOL = 3'd6;

    localparam logic [STAT_W-1:0] ST_FOUND   = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_SIGN = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_CONV = 2'd2;

    // point selection for a slope evaluation
    typedef enum logic [1:0] {
        PT_LEFT  = 2'd0,
        PT_RIGHT = 2'd1,
        PT_MID   = 2'd2
    } point_t;

    typedef struct packed {
        logic   load;       // latch interval, form first midpoint
        logic   eval_start; // start slope evaluation at point
        point_t eval_pt;
        logic   bisect;     // swap ends and form new midpoint
    } peb_cmd_t;

    typedef struct packed {
        logic eval_done;
        logic sign_diff;    // sgn(fl) != sgn(fr)
        logic mid_ok;       // |fm| <= tolerance
    } peb_stat_t;

endpackage

// ===== hdl/peb_datapath.sv =====
// ----------------------------------------------------------------------------
// peb_datapath
// Interval registers, Horner slope unit on one shared multiplier, sign tests.
// ----------------------------------------------------------------------------
module peb_datapath
    import peb_pkg::*;
#(
    parameter int FRAC_BITS  = 24,
    parameter int MAX_DEGREE = 5
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic signed [DATA_W-1:0] coef_in [NUM_COEF],
    input  logic        [TOL_W-1:0]  tol_in,
    input  logic signed [DATA_W-1:0] low_in,
    input  logic signed [DATA_W-1:0] high_in,
    input  peb_cmd_t                 cmd,
    output peb_stat_t                stat,
    output logic signed [DATA_W-1:0] mid_out
);

    localparam logic signed [DATA_W-1:0] POS_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] NEG_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam int PW = 2 * DATA_W;
    localparam int HW = DATA_W / 2;
    localparam int PPW = 2 * HW;
    localparam logic [2:0] TOP_IDX = 3'(MAX_DEGREE);

    typedef enum logic [3:0] {
        H_IDLE = 4'b0001,
        H_DER  = 4'b0010,
        H_VAL  = 4'b0100,
        H_DONE = 4'b1000
    } hstate_t;

    logic signed [DATA_W-1:0] left_reg, right_reg, mid_reg;
    logic signed [DATA_W-1:0] fl_reg, fr_reg, fm_reg;
    logic signed [DATA_W-1:0] x_reg, val_reg, der_reg;
    logic [2:0]               idx_reg;
    point_t                   pt_reg;
    hstate_t                  hs_reg;
    logic [1:0]               mcnt_reg;
    logic [PW-1:0]            prod_reg;
    logic                     neg_reg;

    function automatic logic signed [DATA_W-1:0] half_sum(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        return s[DATA_W:1];
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_add(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1]) begin
            return s[DATA_W] ? NEG_MIN : POS_MAX;
        end
        return s[DATA_W-1:0];
    endfunction

    function automatic logic [1:0] sgn(input logic signed [DATA_W-1:0] v);
        return {v[DATA_W-1], |v};
    endfunction

    function automatic logic [DATA_W-1:0] absv(input logic signed [DATA_W-1:0] v);
        return v[DATA_W-1] ? DATA_W'(-v) : v;
    endfunction

    // multiplier operands: magnitudes
    logic signed [DATA_W-1:0] mul_a;
    logic [DATA_W-1:0]        ma, mb;
    always_comb begin
        mul_a = (hs_reg == H_DER) ? der_reg : val_reg;
        ma    = absv(mul_a);
        mb    = absv(x_reg);
    end

    // one half-by-half partial product per cycle, four per product
    logic [HW-1:0]  pa, pb;
    logic [PPW-1:0] pp;
    logic [PW-1:0]  pp_sh;
    always_comb begin
        pa = mcnt_reg[0] ? ma[DATA_W-1:HW] : ma[HW-1:0];
        pb = mcnt_reg[1] ? mb[DATA_W-1:HW] : mb[HW-1:0];
        pp = PPW'(pa) * PPW'(pb);
        case (mcnt_reg)
            2'd0:    pp_sh = PW'(pp);
            2'd3:    pp_sh = PW'(pp) << (2 * HW);
            default: pp_sh = PW'(pp) << HW;
        endcase
    end

    // rounding and saturation of the registered product
    logic [PW-1:0]            rnd;
    logic [PW-1:0]            r;
    logic signed [DATA_W-1:0] prod_fx;
    always_comb begin
        rnd = prod_reg + (PW'(1) << (FRAC_BITS - 1));
        r   = rnd >> FRAC_BITS;
        if (neg_reg) begin
            if (r >= PW'({1'b1, {(DATA_W-1){1'b0}}})) prod_fx = NEG_MIN;
            else prod_fx = DATA_W'(-r);
        end else begin
            if (r > PW'(POS_MAX)) prod_fx = POS_MAX;
            else prod_fx = r[DATA_W-1:0];
        end
    end

    logic [1:0] sl, sr, sm;
    logic       swap_l, swap_r;
    logic signed [DATA_W-1:0] nl, nr, nm;
    always_comb begin
        sl = sgn(fl_reg);
        sr = sgn(fr_reg);
        sm = sgn(fm_reg);
        swap_l = (sl == sm);
        nl = swap_l ? mid_reg : left_reg;
        nm = swap_l ? left_reg : mid_reg;
        swap_r = (sr == sm);
        nr = swap_r ? nm : right_reg;
    end

    assign stat.eval_done = (hs_reg == H_DONE);
    assign stat.sign_diff = (sl != sr);
    assign stat.mid_ok    = absv(fm_reg) <= {1'b0, tol_in};
    assign mid_out        = mid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hs_reg   <= H_IDLE;
            mcnt_reg <= '0;
        end else begin
            case (hs_reg)
                H_IDLE: begin
                    mcnt_reg <= '0;
                    if (cmd.eval_start) begin
                        hs_reg <= H_DER;
                    end
                end
                H_DER: begin
                    mcnt_reg <= mcnt_reg + 2'd1;
                    if (mcnt_reg == 2'd3) hs_reg <= H_VAL;
                end
                H_VAL: begin
                    if (idx_reg == 3'd0) begin
                        hs_reg   <= H_DONE;
                        mcnt_reg <= '0;
                    end else begin
                        mcnt_reg <= mcnt_reg + 2'd1;
                        if (mcnt_reg == 2'd3) hs_reg <= H_DER;
                    end
                end
                H_DONE: hs_reg <= H_IDLE;
                default: hs_reg <= H_IDLE;
            endcase
        end
    end

    // H_DER: product der*x accumulated; H_VAL: der updated, val*x accumulated;
    // H_DER of next step updates val using prod of val*x.
    logic pending_val_reg;
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            left_reg  <= low_in;
            right_reg <= high_in;
            mid_reg   <= half_sum(low_in, high_in);
        end else if (cmd.bisect) begin
            left_reg  <= nl;
            right_reg <= nr;
            mid_reg   <= half_sum(nl, nr);
        end
        case (hs_reg)
            H_IDLE: begin
                if (cmd.eval_start) begin
                    pt_reg  <= cmd.eval_pt;
                    x_reg   <= (cmd.eval_pt == PT_LEFT) ? left_reg :
                               (cmd.eval_pt == PT_RIGHT) ? right_reg : mid_reg;
                    val_reg <= coef_in[TOP_IDX];
                    der_reg <= '0;
                    idx_reg <= TOP_IDX;
                    pending_val_reg <= 1'b0;
                end
            end
            H_DER: begin
                prod_reg <= (mcnt_reg == 2'd0) ? pp_sh : prod_reg + pp_sh;
                if (mcnt_reg == 2'd0) begin
                    if (pending_val_reg) val_reg <= sat_add(prod_fx, coef_in[idx_reg]);
                    neg_reg  <= (mul_a[DATA_W-1] != x_reg[DATA_W-1]);
                    idx_reg  <= idx_reg - 3'd1;
                end
            end
            H_VAL: begin
                prod_reg <= (mcnt_reg == 2'd0) ? pp_sh : prod_reg + pp_sh;
                if (mcnt_reg == 2'd0) begin
                    der_reg  <= sat_add(prod_fx, val_reg);
                    neg_reg  <= (val_reg[DATA_W-1] != x_reg[DATA_W-1]);
                    pending_val_reg <= 1'b1;
                end
            end
            H_DONE: begin
                case (pt_reg)
                    PT_LEFT:  fl_reg <= der_reg;
                    PT_RIGHT: fr_reg <= der_reg;
                    default:  fm_reg <= der_reg;
                endcase
            end
            default: ;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (hs_reg != H_IDLE) |-> (idx_reg <= TOP_IDX))
        else $error("horner index out of range");
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        (hs_reg == H_DONE) |=> (hs_reg == H_IDLE))
        else $error("done not single cycle");
    a_no_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (hs_reg != H_IDLE) |-> !cmd.eval_start)
        else $error("evaluation started while busy");
`endif

endmodule

// ===== hdl/peb_ctrl.sv =====
// ----------------------------------------------------------------------------
// peb_ctrl
// Sequencer: end and midpoint evaluations, bisection loop, result hand-off.
// ----------------------------------------------------------------------------
module peb_ctrl
    import peb_pkg::*;
#(
    parameter int ITER_CAP = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [STAT_W-1:0] status,
    output logic [STAT_W-1:0] work_status,
    output logic              pos_load,
    output peb_cmd_t          cmd,
    input  peb_stat_t         stat
);

    localparam int CW = $clog2(ITER_CAP + 1);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_EL    = 9'b000000010,
        S_WL    = 9'b000000100,
        S_ER    = 9'b000001000,
        S_WR    = 9'b000010000,
        S_EM    = 9'b000100000,
        S_WM    = 9'b001000000,
        S_TEST  = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     iter_reg, iter_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [STAT_W-1:0] res_status_reg, res_status_next;
    logic              out_valid_reg, out_valid_next;

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = res_status_reg;
    assign work_status = status_reg;

    always_comb begin
        state_next      = state_reg;
        iter_next       = iter_reg;
        status_next     = status_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        pos_load        = 1'b0;
        cmd             = '0;
        cmd.eval_pt     = PT_MID;
        if (out_valid_reg && out_ready) out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (in_valid && in_ready) begin
                    cmd.load   = 1'b1;
                    iter_next  = '0;
                    state_next = S_EL;
                end
            end
            S_EL: begin
                cmd.eval_start = 1'b1;
                cmd.eval_pt    = PT_LEFT;
                state_next     = S_WL;
            end
            S_WL: if (stat.eval_done) state_next = S_ER;
            S_ER: begin
                cmd.eval_start = 1'b1;
                cmd.eval_pt    = PT_RIGHT;
                state_next     = S_WR;
            end
            S_WR: if (stat.eval_done) state_next = S_EM;
            S_EM: begin
                cmd.eval_start = 1'b1;
                cmd.eval_pt    = PT_MID;
                state_next     = S_WM;
            end
            S_WM: if (stat.eval_done) state_next = S_TEST;
            S_TEST: begin
                if (iter_reg == CW'(0) && !stat.sign_diff) begin
                    status_next = ST_NO_SIGN;
                    state_next  = S_OUT;
                end else if (stat.mid_ok) begin
                    status_next = ST_FOUND;
                    state_next  = S_OUT;
                end else if (!stat.sign_diff) begin
                    status_next = ST_NO_SIGN;
                    state_next  = S_OUT;
                end else if (iter_reg == CW'(ITER_CAP)) begin
                    status_next = ST_NO_CONV;
                    state_next  = S_OUT;
                end else begin
                    cmd.bisect = 1'b1;
                    iter_next  = iter_reg + CW'(1);
                    state_next = S_EM;
                end
            end
            S_OUT: begin
                if (!out_valid_reg || out_ready) begin
                    pos_load        = 1'b1;
                    res_status_next = status_reg;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            iter_reg       <= '0;
            status_reg     <= ST_FOUND;
            res_status_reg <= ST_FOUND;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            iter_reg       <= iter_next;
            status_reg     <= status_next;
            res_status_reg <= res_status_next;
            out_valid_reg  <= out_valid_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_iter_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        iter_reg <= CW'(ITER_CAP))
        else $error("iteration count past cap");
    a_status_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (res_status_reg != 2'd3))
        else $error("illegal status");
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item accepted while busy");
`endif

endmodule

// ===== hdl/polynomial_extremum_bisection.sv =====
// ----------------------------------------------------------------------------
// polynomial_extremum_bisection
// Bisection search for a zero of p'(x), Horner slope on one shared multiplier.
// ----------------------------------------------------------------------------
// channel   direction  ports
// s_        in         s_valid s_ready s_interval_low s_interval_high
// m_        out        m_valid m_ready m_extremum_position m_status
// cfg       in         cfg_we cfg_index cfg_data
//
// One item at a time. Each product is summed from four partial products on a 24x24
// multiplier; an item takes slope evaluations at both ends and at the first midpoint,
// then one more per bisection step, up to ITER_CAP steps.
// Reset is synchronous. A result waits in the output register while the next item
// is taken; that item stalls at its end only while the previous result still waits.
// ----------------------------------------------------------------------------
module polynomial_extremum_bisection
    import peb_pkg::*;
#(
    parameter int FRAC_BITS  = 24,
    parameter int ITER_CAP   = 64,
    parameter int MAX_DEGREE = 5
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [IDX_W-1:0]         cfg_index,
    input  logic [DATA_W-1:0]        cfg_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [DATA_W-1:0] s_interval_low,
    input  logic signed [DATA_W-1:0] s_interval_high,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_extremum_position,
    output logic [STAT_W-1:0]        m_status
);

    logic signed [DATA_W-1:0] coef_reg [NUM_COEF];
    logic [TOL_W-1:0]         tol_reg;
    logic signed [DATA_W-1:0] pos_reg, mid;
    logic                     pos_load;
    logic [STAT_W-1:0]        status;
    peb_cmd_t                 cmd;
    peb_stat_t                stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_COEF; i++) coef_reg[i] <= '0;
            tol_reg <= '0;
        end else if (cfg_we) begin
            if (cfg_index < IDX_W'(NUM_COEF)) coef_reg[cfg_index] <= cfg_data;
            else if (cfg_index == REG_TOL) tol_reg <= cfg_data[TOL_W-1:0];
        end
    end

    logic busy_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) busy_reg <= 1'b0;
        else if (s_valid && s_ready) busy_reg <= 1'b1;
        else if (pos_load) busy_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (pos_load) pos_reg <= (status == ST_FOUND) ? mid : '0;
    end

    peb_ctrl #(.ITER_CAP(ITER_CAP)) u_ctrl (
        .aclk, .aresetn,
        .in_valid(s_valid), .in_ready(s_ready),
        .out_valid(m_valid), .out_ready(m_ready),
        .status(m_status), .work_status(status), .pos_load, .cmd, .stat
    );

    peb_datapath #(.FRAC_BITS(FRAC_BITS), .MAX_DEGREE(MAX_DEGREE)) u_dp (
        .aclk, .aresetn,
        .coef_in(coef_reg), .tol_in(tol_reg),
        .low_in(s_interval_low), .high_in(s_interval_high),
        .cmd, .stat, .mid_out(mid)
    );

    assign m_extremum_position = pos_reg;

`ifndef NO_ASSERTIONS
    a_busy_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !s_ready)
        else $error("ready while item in work");
    a_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_load |=> m_valid)
        else $error("result not presented");
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_FOUND) |-> (m_extremum_position == '0))
        else $error("nonzero position on error");
`endif

endmodule

// ===== test/peb_checker.sv =====
// ----------------------------------------------------------------------------
// peb_checker
// Watches the config port and both item channels of the extremum bisection
// block, predicts the result of each accepted query and compares it field by
// field with the results that leave the block, in order.
// ----------------------------------------------------------------------------
module peb_checker
    import peb_pkg::*;
#(
    parameter int FRAC_BITS  = 24,
    parameter int ITER_CAP   = 64,
    parameter int MAX_DEGREE = 5
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [IDX_W-1:0]         cfg_index,
    input  logic [DATA_W-1:0]        cfg_data,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic signed [DATA_W-1:0] s_interval_low,
    input  logic signed [DATA_W-1:0] s_interval_high,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic signed [DATA_W-1:0] m_extremum_position,
    input  logic [STAT_W-1:0]        m_status,
    output int                       errors,
    output int                       pending,
    output int                       n_checked,
    output int                       n_found,
    output int                       n_no_sign,
    output int                       n_no_conv
);

    localparam longint POS_MAX = 64'sh7FFF_FFFF_FFFF;
    localparam longint NEG_MIN = -64'sh8000_0000_0000;

    typedef struct {
        longint           position;
        logic [STAT_W-1:0] status;
    } extremum_t;

    longint    coefs [NUM_COEF];
    longint    tolerance;
    extremum_t expected_q [$];

    function automatic longint sat48(longint v);
        if (v > POS_MAX) return POS_MAX;
        if (v < NEG_MIN) return NEG_MIN;
        return v;
    endfunction

    function automatic longint fx_mult(longint a, longint b);
        logic [47:0] ma, mb;
        logic [95:0] p;
        bit          neg;
        neg = (a < 0) != (b < 0);
        ma  = (a < 0) ? 48'(-a) : 48'(a);
        mb  = (b < 0) ? 48'(-b) : 48'(b);
        p   = {48'd0, ma} * {48'd0, mb};
        p   = (p + (96'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (neg) begin
            if (p >= 96'h8000_0000_0000) return NEG_MIN;
            return -longint'(p[63:0]);
        end
        if (p > 96'h7FFF_FFFF_FFFF) return POS_MAX;
        return longint'(p[63:0]);
    endfunction

    function automatic longint slope(longint x);
        longint val, der;
        val = coefs[MAX_DEGREE];
        der = 0;
        for (int i = MAX_DEGREE - 1; i >= 0; i--) begin
            der = sat48(fx_mult(der, x) + val);
            val = sat48(fx_mult(val, x) + coefs[i]);
        end
        return der;
    endfunction

    function automatic int sgn(longint v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic extremum_t find_extremum(longint lo, longint hi);
        longint    left, right, mid, fl, fr, fm, t;
        int        iter;
        extremum_t r;
        left  = lo;
        right = hi;
        mid   = (left + right) >>> 1;
        fl    = slope(left);
        fr    = slope(right);
        fm    = slope(mid);
        iter  = 0;
        r.position = 0;
        if (sgn(fl) == sgn(fr)) begin
            r.status = ST_NO_SIGN;
            return r;
        end
        while (iter < ITER_CAP && sgn(fl) != sgn(fr) && mag(fm) > tolerance) begin
            if (sgn(fl) == sgn(fm)) begin
                t = left; left = mid; mid = t;
                t = fl;   fl = fm;    fm = t;
            end
            if (sgn(fr) == sgn(fm)) begin
                t = right; right = mid; mid = t;
                t = fr;    fr = fm;     fm = t;
            end
            mid = (left + right) >>> 1;
            fm  = slope(mid);
            iter++;
        end
        if (mag(fm) <= tolerance) begin
            r.status   = ST_FOUND;
            r.position = mid;
        end else if (sgn(fl) != sgn(fr)) begin
            r.status = ST_NO_CONV;
        end else begin
            r.status = ST_NO_SIGN;
        end
        return r;
    endfunction

    assign pending = expected_q.size();

    always @(posedge aclk) begin
        extremum_t e;
        if (!aresetn) begin
            foreach (coefs[i]) coefs[i] = 0;
            tolerance = 0;
            expected_q.delete();
            errors = 0; n_checked = 0; n_found = 0; n_no_sign = 0; n_no_conv = 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index < REG_TOL) coefs[cfg_index] = longint'($signed(cfg_data));
                else if (cfg_index == REG_TOL) tolerance = longint'(cfg_data[TOL_W-1:0]);
            end
            if (s_valid && s_ready)
                expected_q.push_back(find_extremum(longint'(s_interval_low),
                                                   longint'(s_interval_high)));
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result pos=%0d status=%0d", $time,
                             m_extremum_position, m_status);
                end else begin
                    e = expected_q.pop_front();
                    n_checked++;
                    case (e.status)
                        ST_FOUND:   n_found++;
                        ST_NO_SIGN: n_no_sign++;
                        default:    n_no_conv++;
                    endcase
                    if (m_status !== e.status) begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d", $time,
                                 e.status, m_status);
                    end
                    if (longint'(m_extremum_position) !== e.position) begin
                        errors++;
                        $display("%0t: position expected %0d actual %0d", $time,
                                 e.position, m_extremum_position);
                    end
                end
            end
        end
    end

endmodule

// ===== test/tb_polynomial_extremum_bisection.sv =====
// ----------------------------------------------------------------------------
// tb_polynomial_extremum_bisection
// Drives interval queries through a range of polynomial and tolerance
// settings with bursty input and random output stalls; the checker predicts
// and compares every result.
// ----------------------------------------------------------------------------
module tb_polynomial_extremum_bisection;
    import peb_pkg::*;

    localparam longint ONE     = 64'sd1 << 24;
    localparam longint POS_MAX = 64'sh7FFF_FFFF_FFFF;
    localparam longint NEG_MIN = -64'sh8000_0000_0000;
    localparam longint LIMIT   = 10_000_000;

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_we;
    logic [IDX_W-1:0]         cfg_index;
    logic [DATA_W-1:0]        cfg_data;
    logic                     s_valid;
    logic                     s_ready;
    logic signed [DATA_W-1:0] s_interval_low;
    logic signed [DATA_W-1:0] s_interval_high;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [DATA_W-1:0] m_extremum_position;
    logic [STAT_W-1:0]        m_status;

    int     errors, pending, n_checked, n_found, n_no_sign, n_no_conv;
    int     burst_left;
    int     ready_pct = 100;
    longint cycles = 0;

    polynomial_extremum_bisection dut (.*);
    peb_checker chk (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // receiver stall pattern: random ready with a duty that is redrawn from time to time
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles % 300 == 0) begin
            case ($urandom_range(0, 3))
                0: ready_pct <= 100;
                1: ready_pct <= 70;
                2: ready_pct <= 30;
                default: ready_pct <= 5;
            endcase
        end
        m_ready <= ($urandom_range(0, 99) < ready_pct);
        if (cycles > LIMIT) begin
            $display("timeout at cycle %0d", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic longint rand48();
        return longint'($signed(48'({$urandom, $urandom})));
    endfunction

    // random Q value in [-span, span] units, plus 0 to 15 LSBs
    function automatic longint rand_q(int span);
        return longint'($urandom_range(0, 2 * span * (1 << 20))) * 16
               - longint'(span) * ONE + $urandom_range(0, 15);
    endfunction

    task automatic write_reg(logic [IDX_W-1:0] idx, longint val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[DATA_W-1:0];
        @(posedge aclk);
    endtask

    task automatic set_poly(longint c0, longint c1, longint c2, longint c3,
                            longint c4, longint c5, longint tol);
        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        write_reg(REG_COEF0, c0); write_reg(REG_COEF1, c1); write_reg(REG_COEF2, c2);
        write_reg(REG_COEF3, c3); write_reg(REG_COEF4, c4); write_reg(REG_COEF5, c5);
        write_reg(REG_TOL, tol);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send(longint lo, longint hi);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_valid         <= 1'b1;
        s_interval_low  <= lo[DATA_W-1:0];
        s_interval_high <= hi[DATA_W-1:0];
        forever begin
            @(negedge aclk);
            if (s_ready) break;
        end
        @(posedge aclk);
    endtask

    task automatic random_item();
        int k;
        longint lo, hi;
        k = $urandom_range(0, 9);
        if (k < 8) begin
            lo = -longint'($urandom_range(0, 8 << 20)) * 16 - $urandom_range(0, 15);
            hi = longint'($urandom_range(0, 8 << 20)) * 16 + $urandom_range(0, 15);
            if (k == 7) send(hi, lo);
            else        send(lo, hi);
        end else begin
            send(rand48(), rand48());
        end
    endtask

    initial begin
        longint tol;
        aresetn = 0; cfg_we = 0; cfg_index = '0; cfg_data = '0;
        s_valid = 0; s_interval_low = '0; s_interval_high = '0;
        burst_left = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset config: zero slope everywhere
        send(NEG_MIN, POS_MAX);
        send(0, 0);

        // p = x^2 - x/4 + tiny linear offset; root of p' not exact
        set_poly(0, -(ONE / 4) + 1, ONE, 0, 0, 0, 0);
        send(-ONE, 3 * ONE);
        send(3 * ONE, -ONE);
        send(NEG_MIN, POS_MAX);
        send(POS_MAX, NEG_MIN);
        send(-1, 1);
        send(ONE, 2 * ONE);
        set_poly(0, -(ONE / 4), ONE, 0, 0, 0, 1 << 10);
        send(-ONE, 3 * ONE);
        send(-4 * ONE, ONE / 2);

        // extreme coefficients with max tolerance, then with zero tolerance
        set_poly(POS_MAX, NEG_MIN, POS_MAX, NEG_MIN, POS_MAX, NEG_MIN,
                 64'sh7FFF_FFFF_FFFF);
        send(NEG_MIN, POS_MAX);
        send(-ONE, ONE);
        send(POS_MAX, POS_MAX);
        set_poly(NEG_MIN, POS_MAX, NEG_MIN, POS_MAX, NEG_MIN, POS_MAX, 0);
        send(NEG_MIN, POS_MAX);
        send(-ONE, ONE);
        send(-2, 3);

        // cubic with two extrema
        set_poly(ONE, -3 * ONE, 0, ONE, 0, 0, 1 << 8);
        send(0, 4 * ONE);
        send(-4 * ONE, 0);
        send(-4 * ONE, 4 * ONE);

        for (int ph = 0; ph < 11; ph++) begin
            case ($urandom_range(0, 3))
                0: tol = 0;
                1: tol = $urandom_range(0, 1 << 12);
                2: tol = $urandom_range(0, 1 << 22);
                default: tol = 64'sh7FFF_FFFF_FFFF;
            endcase
            if (ph == 5)
                set_poly(rand48(), rand48(), rand48(), rand48(), rand48(), rand48(),
                         tol);
            else
                set_poly(rand_q(2), rand_q(2), rand_q(2), rand_q(1),
                         ($urandom_range(0, 1) ? rand_q(1) / 4 : 0),
                         ($urandom_range(0, 1) ? rand_q(1) / 16 : 0), tol);
            for (int n = 0; n < 50; n++) begin
                random_item();
                if (ph == 3 && n == 25) begin
                    s_valid <= 1'b0;
                    while (pending != 0) @(posedge aclk);
                    burst_left = 0;
                end
            end
        end
        s_valid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (1000) @(posedge aclk);
        $display("checked %0d results: %0d found, %0d without sign change, %0d capped",
                 n_checked, n_found, n_no_sign, n_no_conv);
        $display("over 17 coefficient/tolerance settings incl. extremes and reset values");
        if (errors == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
